/* hdl/aost_pkg.sv */
// Shared definitions for the A* open-set table: field widths, operation and
// status codes, register indexes and the controller/datapath interface structs.
// No dependencies.
package aost_pkg;

  localparam int SLOTS_DEF      = 64;
  localparam int ID_BITS_DEF    = 16;
  localparam int COORD_BITS_DEF = 8;

  localparam int KIND_W   = 2;
  localparam int ID_W     = 16;
  localparam int COORD_W  = 8;
  localparam int COST_W   = 16;
  localparam int STATUS_W = 3;
  localparam int REG_W    = 8;
  localparam int REGIDX_W = 1;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOWEST = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

  localparam logic [REGIDX_W-1:0] REG_GOAL_ROW = 1'd0;
  localparam logic [REGIDX_W-1:0] REG_GOAL_COL = 1'd1;

  typedef struct packed {
    logic load;
    logic rewind;
    logic clr;
    logic scan_en;
    logic fix_en;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic              scan_done;
    logic              found;
    logic [KIND_W-1:0] kind;
  } sts_t;

endpackage

/* hdl/aost_ctrl.sv */
// Controller for the open-set table: sequences the slot scan, the rank fixup
// pass after a remove that hits, and the result word.
// Depends on aost_pkg.
module aost_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  aost_pkg::sts_t sts,
  output aost_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FIX    = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cmd.rewind = 1'b1;
          cmd.clr    = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          if (sts.kind == aost_pkg::KIND_REMOVE && sts.found) begin
            cmd.rewind = 1'b1;
            state_next = S_FIX;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_FIX: begin
        cmd.fix_en = 1'b1;
        if (sts.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* hdl/aost_dp.sv */
// Datapath for the open-set table: goal registers, score arithmetic, slot
// memories with valid bits, scan trackers and the result registers.
// Depends on aost_pkg.
module aost_dp #(
  parameter int SLOTS      = aost_pkg::SLOTS_DEF,
  parameter int ID_BITS    = aost_pkg::ID_BITS_DEF,
  parameter int COORD_BITS = aost_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  aost_pkg::cmd_t                   cmd,
  output aost_pkg::sts_t                   sts,
  input  logic [aost_pkg::KIND_W-1:0]      kind,
  input  logic [aost_pkg::ID_W-1:0]        node_id,
  input  logic [aost_pkg::COORD_W-1:0]     node_row,
  input  logic [aost_pkg::COORD_W-1:0]     node_col,
  input  logic                             has_parent,
  input  logic [aost_pkg::COST_W-1:0]      parent_cost,
  input  logic [aost_pkg::COST_W-1:0]      start_cost,
  input  logic                             wr_en,
  input  logic [aost_pkg::REGIDX_W-1:0]    wr_index,
  input  logic [aost_pkg::REG_W-1:0]       wr_data,
  output logic                             done,
  output logic [aost_pkg::STATUS_W-1:0]    status,
  output logic [aost_pkg::ID_W-1:0]        found_id,
  output logic [aost_pkg::COST_W-1:0]      found_score,
  output logic [aost_pkg::COST_W-1:0]      found_cost
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = aost_pkg::COST_W;
  localparam logic [CW-1:0] LAST = CW'(SLOTS);

  // config
  logic [COORD_BITS-1:0] goal_row;
  logic [COORD_BITS-1:0] goal_col;

  // captured operation
  logic [aost_pkg::KIND_W-1:0] op_kind;
  logic [ID_BITS-1:0]          op_id;
  logic [COORD_BITS-1:0]       op_row;
  logic [COORD_BITS-1:0]       op_col;
  logic                        op_has_parent;
  logic [SW-1:0]               op_parent_cost;
  logic [SW-1:0]               op_start_cost;

  // scoring
  logic [SW:0]           parent_inc;
  logic [SW-1:0]         cost_next;
  logic [COORD_BITS-1:0] diff_row;
  logic [COORD_BITS-1:0] diff_col;
  logic [COORD_BITS:0]   hdist_next;
  logic [SW+1:0]         score_sum;
  logic [SW-1:0]         cost;
  logic [COORD_BITS:0]   hdist;
  logic [SW-1:0]         score;

  // slot storage
  logic [ID_BITS-1:0] mem_node  [SLOTS];
  logic [SW-1:0]      mem_score [SLOTS];
  logic [IW-1:0]      mem_stamp [SLOTS];
  logic [SLOTS-1:0]   valid;
  logic [CW-1:0]      count;

  // scan pipeline
  logic [CW-1:0]      idx;
  logic               step;
  logic [IW-1:0]      rd_addr;
  logic               rd_v;
  logic [IW-1:0]      rd_idx;
  logic               slot_v;
  logic [ID_BITS-1:0] rd_node;
  logic [SW-1:0]      rd_score;
  logic [IW-1:0]      rd_stamp;

  // trackers
  logic               found;
  logic [IW-1:0]      hit_idx;
  logic [IW-1:0]      hit_stamp;
  logic               free_found;
  logic [IW-1:0]      free_idx;
  logic               best_v;
  logic [ID_BITS-1:0] best_node;
  logic [SW-1:0]      best_score;
  logic [IW-1:0]      best_stamp;
  logic               better;

  // writes
  logic          add_ok;
  logic          rm_ok;
  logic          fix_we;
  logic          st_we;
  logic [IW-1:0] st_addr;
  logic [IW-1:0] st_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_row <= '0;
      goal_col <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        aost_pkg::REG_GOAL_ROW: goal_row <= COORD_BITS'(wr_data);
        aost_pkg::REG_GOAL_COL: goal_col <= COORD_BITS'(wr_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind        <= kind;
      op_id          <= ID_BITS'(node_id);
      op_row         <= COORD_BITS'(node_row);
      op_col         <= COORD_BITS'(node_col);
      op_has_parent  <= has_parent;
      op_parent_cost <= parent_cost;
      op_start_cost  <= start_cost;
    end
  end

  always_comb begin
    parent_inc = {1'b0, op_parent_cost} + (SW + 1)'(1);
    if (op_has_parent) begin
      cost_next = parent_inc[SW] ? {SW{1'b1}} : parent_inc[SW-1:0];
    end else begin
      cost_next = op_start_cost;
    end
    diff_row   = (op_row >= goal_row) ? op_row - goal_row : goal_row - op_row;
    diff_col   = (op_col >= goal_col) ? op_col - goal_col : goal_col - op_col;
    hdist_next = {1'b0, diff_row} + {1'b0, diff_col};
    score_sum  = (SW + 2)'(cost) + (SW + 2)'(hdist);
  end

  // free-running; settles well before the scan ends
  always_ff @(posedge clk) begin
    cost  <= cost_next;
    hdist <= hdist_next;
    score <= (|score_sum[SW+1:SW]) ? {SW{1'b1}} : score_sum[SW-1:0];
  end

  assign step    = (cmd.scan_en | cmd.fix_en) && (idx != LAST);
  assign rd_addr = idx[IW-1:0];

  assign add_ok = cmd.finish && (op_kind == aost_pkg::KIND_ADD) && !found && free_found;
  assign rm_ok  = cmd.finish && (op_kind == aost_pkg::KIND_REMOVE) && found;
  assign fix_we = cmd.fix_en && rd_v && slot_v && (rd_stamp > hit_stamp);
  assign st_we  = add_ok | fix_we;
  assign st_addr = add_ok ? free_idx : rd_idx;
  assign st_data = add_ok ? count[IW-1:0] : rd_stamp - IW'(1);

  always_ff @(posedge clk) begin
    if (add_ok) begin
      mem_node[free_idx] <= op_id;
    end
    if (step) begin
      rd_node <= mem_node[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (add_ok) begin
      mem_score[free_idx] <= score;
    end
    if (step) begin
      rd_score <= mem_score[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      mem_stamp[st_addr] <= st_data;
    end
    if (step) begin
      rd_stamp <= mem_stamp[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rd_idx <= rd_addr;
      slot_v <= valid[rd_addr];
    end
  end

  assign better = !best_v || (rd_score < best_score) ||
                  ((rd_score == best_score) && (rd_stamp < best_stamp));

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      rd_v       <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      best_v     <= 1'b0;
      valid      <= '0;
      count      <= '0;
      done       <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.rewind) begin
        idx  <= '0;
        rd_v <= 1'b0;
      end else begin
        rd_v <= step;
        if (step) begin
          idx <= idx + CW'(1);
        end
      end
      if (cmd.clr) begin
        found      <= 1'b0;
        free_found <= 1'b0;
        best_v     <= 1'b0;
      end else if (cmd.scan_en && rd_v) begin
        if (slot_v && (rd_node == op_id) && !found) begin
          found <= 1'b1;
        end
        if (!slot_v && !free_found) begin
          free_found <= 1'b1;
        end
        if (slot_v && better) begin
          best_v <= 1'b1;
        end
      end
      if (add_ok) begin
        valid[free_idx] <= 1'b1;
        count           <= count + CW'(1);
      end
      if (rm_ok) begin
        valid[hit_idx] <= 1'b0;
        if (count != '0) begin
          count <= count - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en && rd_v) begin
      if (slot_v && (rd_node == op_id) && !found) begin
        hit_idx   <= rd_idx;
        hit_stamp <= rd_stamp;
      end
      if (!slot_v && !free_found) begin
        free_idx <= rd_idx;
      end
      if (slot_v && better) begin
        best_node  <= rd_node;
        best_score <= rd_score;
        best_stamp <= rd_stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status      <= aost_pkg::ST_OK;
      found_id    <= '0;
      found_score <= '0;
      found_cost  <= '0;
      case (op_kind)
        aost_pkg::KIND_ADD: begin
          found_id    <= aost_pkg::ID_W'(op_id);
          found_score <= score;
          found_cost  <= cost;
          if (found) begin
            status <= aost_pkg::ST_PRESENT;
          end else if (!free_found) begin
            status <= aost_pkg::ST_FULL;
          end
        end
        aost_pkg::KIND_REMOVE: begin
          found_id <= aost_pkg::ID_W'(op_id);
          if (!found) begin
            status <= aost_pkg::ST_ABSENT;
          end
        end
        aost_pkg::KIND_LOWEST: begin
          if (!best_v) begin
            status <= aost_pkg::ST_EMPTY;
          end else begin
            found_id    <= aost_pkg::ID_W'(best_node);
            found_score <= best_score;
          end
        end
        default: ;
      endcase
    end
  end

  assign sts.scan_done = (idx == LAST) && !rd_v;
  assign sts.found     = found;
  assign sts.kind      = op_kind;

endmodule

/* hdl/astar_open_set_table.sv */
// Open-set table for A* path search: add, remove and lowest-score lookup.
// done rises after a scan of every slot and the finish state; a remove that hits
// also runs a rank fixup pass over the slots before finishing. A new word is taken
// only while busy is low, once the one-slot-per-cycle scan of slot memory is done.
// The result is shown for one cycle on done; the receiver cannot stall.
// Reset (rst, synchronous) empties the table at once and zeroes the goal.
module astar_open_set_table #(
  parameter int SLOTS      = aost_pkg::SLOTS_DEF,
  parameter int ID_BITS    = aost_pkg::ID_BITS_DEF,
  parameter int COORD_BITS = aost_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [aost_pkg::KIND_W-1:0]      kind,
  input  logic [aost_pkg::ID_W-1:0]        node_id,
  input  logic [aost_pkg::COORD_W-1:0]     node_row,
  input  logic [aost_pkg::COORD_W-1:0]     node_col,
  input  logic                             has_parent,
  input  logic [aost_pkg::COST_W-1:0]      parent_cost,
  input  logic [aost_pkg::COST_W-1:0]      start_cost,
  input  logic                             wr_en,
  input  logic [aost_pkg::REGIDX_W-1:0]    wr_index,
  input  logic [aost_pkg::REG_W-1:0]       wr_data,
  output logic                             done,
  output logic [aost_pkg::STATUS_W-1:0]    status,
  output logic [aost_pkg::ID_W-1:0]        found_id,
  output logic [aost_pkg::COST_W-1:0]      found_score,
  output logic [aost_pkg::COST_W-1:0]      found_cost
);

  aost_pkg::cmd_t cmd;
  aost_pkg::sts_t sts;

  aost_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  aost_dp #(
    .SLOTS      (SLOTS),
    .ID_BITS    (ID_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .kind        (kind),
    .node_id     (node_id),
    .node_row    (node_row),
    .node_col    (node_col),
    .has_parent  (has_parent),
    .parent_cost (parent_cost),
    .start_cost  (start_cost),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .done        (done),
    .status      (status),
    .found_id    (found_id),
    .found_score (found_score),
    .found_cost  (found_cost)
  );

endmodule
